### design/assert_macros.svh
// Assertion macros used by the simplifier top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### design/pdas_pkg.sv
// Shared constants and types of the polyline simplifier.
package pdas_pkg;

	localparam int LIMB_BITS    = 32;
	localparam int DIST_BITS    = 34;
	localparam int COS_BITS     = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [DIST_BITS-1:0]       MIN_DIST_RST = '0;
	localparam logic [DIST_BITS-1:0]       MAX_DIST_RST = '1;
	localparam logic signed [COS_BITS-1:0] COS_RST      = 16'sh7fff;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MIN_DIST = 2'd0,
		CFG_MAX_DIST = 2'd1,
		CFG_COS      = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic clr;
		logic issue;
		logic neg;
	} mac_ctl_t;

endpackage

### design/pdas_if.sv
// Point stream interfaces: input points and kept points.
interface pdas_in_if #(parameter int COORD_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic                         end_of_curve;

	modport source (output valid, point_x, point_y, point_z, end_of_curve, input ready);
	modport sink (input valid, point_x, point_y, point_z, end_of_curve, output ready);
endinterface

interface pdas_out_if #(parameter int COORD_BITS = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] kept_x;
	logic signed [COORD_BITS-1:0] kept_y;
	logic signed [COORD_BITS-1:0] kept_z;
	logic                         final_point;

	modport source (output valid, kept_x, kept_y, kept_z, final_point, input ready);
	modport sink (input valid, kept_x, kept_y, kept_z, final_point, output ready);
endinterface

### design/polyline_distance_angle_simplify_top.sv
// Streaming 3D polyline simplifier by segment length and turning angle.
//
// in_pt carries one point word per handshake (x, y, z, end_of_curve); out_pt
// carries kept points (x, y, z, final_point). Registers are written through
// cfg_wr_en / cfg_index / cfg_data: 0 min_distance_sq, 1 max_distance_sq,
// 2 cos_threshold (Q1.15); other indexes are ignored.
// One point is handled at a time; in_pt.ready is high only while idle.
// The first and second points of a curve go straight to the emit step. Later
// points run the shared 32x32 multiply-accumulate unit: squared lengths, dot
// product, then the angle test on the full-width products. The length test,
// a zero first or second segment or the dot-product sign may decide early;
// otherwise the full angle test runs.
// Kept points go to a two-entry output queue, so a point may be accepted
// while results wait; if the receiver stalls and the queue is full, the
// block holds in its emit step until space frees up.
// Reset empties the queue, clears anchor, pending point and point count, and
// loads min 0, max 2^34-1 and cosine 32767.
`include "assert_macros.svh"

module polyline_distance_angle_simplify_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [pdas_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [pdas_pkg::DIST_BITS-1:0]       cfg_data,
	pdas_in_if.sink                              in_pt,
	pdas_out_if.source                           out_pt
);
	import pdas_pkg::*;

	localparam int DW     = COORD_BITS + 1;
	localparam int NW     = 2*COORD_BITS + 2;
	localparam int PW     = 4*COORD_BITS + 4;
	localparam int C2W    = 2*COS_BITS - 1;
	localparam int RW     = PW + C2W;
	localparam int LSHIFT = 2*COS_BITS - 2;
	localparam int DCW    = (NW > DIST_BITS) ? NW : DIST_BITS;
	localparam int NLD    = (DW + LIMB_BITS - 1) / LIMB_BITS;
	localparam int NLN    = (NW + LIMB_BITS - 1) / LIMB_BITS;
	localparam int NLP    = (PW + LIMB_BITS - 1) / LIMB_BITS;
	localparam int OPW    = NLP * LIMB_BITS;
	localparam int LIW    = (NLP > 1) ? $clog2(NLP) : 1;
	localparam int AW     = OPW + LIMB_BITS + 1;

	localparam logic [LIW-1:0] LD_M1 = LIW'(NLD - 1);
	localparam logic [LIW-1:0] LN_M1 = LIW'(NLN - 1);
	localparam logic [LIW-1:0] LP_M1 = LIW'(NLP - 1);

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_DIFF, S_MUL, S_WAIT, S_STORE, S_EMIT_A, S_EMIT_B
	} state_t;

	typedef enum logic [2:0] {
		OP_N0, OP_N1, OP_DOT, OP_DM2, OP_NN, OP_C2, OP_R
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic [1:0]     k_q;
	logic [LIW-1:0] i_q;
	logic [LIW-1:0] j_q;
	logic [1:0]     seen_q;
	logic           keep_q;
	logic           eoc_q;

	logic signed [COORD_BITS-1:0] anchor_q  [3];
	logic signed [COORD_BITS-1:0] pending_q [3];
	logic signed [COORD_BITS-1:0] new_q     [3];

	logic [DIST_BITS-1:0]       min_q;
	logic [DIST_BITS-1:0]       max_q;
	logic signed [COS_BITS-1:0] cos_q;

	logic [DW-1:0]       m0_q [3];
	logic [DW-1:0]       m1_q [3];
	logic [2:0]          s0_q;
	logic [2:0]          s1_q;
	logic [COS_BITS-1:0] cm_q;
	logic                cneg_q;
	logic [NW-1:0]       n0_q;
	logic [NW-1:0]       n1_q;
	logic [NW-1:0]       dm_q;
	logic [PW-1:0]       l_q;
	logic [PW-1:0]       t_q;
	logic [C2W-1:0]      c2_q;

	logic signed [DW-1:0] d0 [3];
	logic signed [DW-1:0] d1 [3];
	logic [DW-1:0]        m0_c [3];
	logic [DW-1:0]        m1_c [3];
	logic [COS_BITS-1:0]  cm_c;

	mac_ctl_t             mac_ctl;
	logic [OPW-1:0]       x_op;
	logic [OPW-1:0]       y_op;
	logic [LIW-1:0]       nx_m1;
	logic [LIW-1:0]       ny_m1;
	logic                 three_terms;
	logic signed [AW-1:0] acc;

	logic [DCW-1:0] n0_ext;
	logic           n0_lt_min;
	logic           n0_gt_max;
	logic           acc_zero;
	logic           dot_neg;
	logic [AW-1:0]  acc_abs;
	logic [RW-1:0]  l_sh;
	logic [RW-1:0]  r_val;
	logic           angle_keep;

	logic                  need_b;
	logic                  push_a;
	logic                  push_b;
	logic                  fifo_push;
	logic                  fifo_full;
	logic [3*COORD_BITS:0] push_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_DIST_RST;
			max_q <= MAX_DIST_RST;
			cos_q <= COS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIN_DIST: min_q <= cfg_data;
				CFG_MAX_DIST: max_q <= cfg_data;
				CFG_COS:      cos_q <= cfg_data[COS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// segment differences and magnitudes
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d0[k] = {pending_q[k][COORD_BITS-1], pending_q[k]} -
				{anchor_q[k][COORD_BITS-1], anchor_q[k]};
			d1[k] = {new_q[k][COORD_BITS-1], new_q[k]} -
				{pending_q[k][COORD_BITS-1], pending_q[k]};
			m0_c[k] = d0[k][DW-1] ? (~d0[k] + 1'b1) : d0[k];
			m1_c[k] = d1[k][DW-1] ? (~d1[k] + 1'b1) : d1[k];
		end
		cm_c = cos_q[COS_BITS-1] ? (~cos_q + 1'b1) : cos_q;
	end

	// operand select for the shared unit
	always_comb begin
		x_op        = '0;
		y_op        = '0;
		nx_m1       = '0;
		ny_m1       = '0;
		three_terms = 1'b0;
		case (op_q)
			OP_N0: begin
				x_op        = OPW'(m0_q[k_q]);
				y_op        = OPW'(m0_q[k_q]);
				nx_m1       = LD_M1;
				ny_m1       = LD_M1;
				three_terms = 1'b1;
			end
			OP_N1: begin
				x_op        = OPW'(m1_q[k_q]);
				y_op        = OPW'(m1_q[k_q]);
				nx_m1       = LD_M1;
				ny_m1       = LD_M1;
				three_terms = 1'b1;
			end
			OP_DOT: begin
				x_op        = OPW'(m0_q[k_q]);
				y_op        = OPW'(m1_q[k_q]);
				nx_m1       = LD_M1;
				ny_m1       = LD_M1;
				three_terms = 1'b1;
			end
			OP_DM2: begin
				x_op  = OPW'(dm_q);
				y_op  = OPW'(dm_q);
				nx_m1 = LN_M1;
				ny_m1 = LN_M1;
			end
			OP_NN: begin
				x_op  = OPW'(n0_q);
				y_op  = OPW'(n1_q);
				nx_m1 = LN_M1;
				ny_m1 = LN_M1;
			end
			OP_C2: begin
				x_op = OPW'(cm_q);
				y_op = OPW'(cm_q);
			end
			OP_R: begin
				x_op  = OPW'(c2_q);
				y_op  = OPW'(t_q);
				ny_m1 = LP_M1;
			end
			default: ;
		endcase
	end

	assign mac_ctl = '{
		clr:   (state_q == S_DIFF) || (state_q == S_STORE),
		issue: (state_q == S_MUL),
		neg:   (op_q == OP_DOT) && (s0_q[k_q] ^ s1_q[k_q])
	};

	pdas_mac #(
		.OPW (OPW),
		.LIW (LIW),
		.AW  (AW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x      (x_op),
		.y      (y_op),
		.xi     (i_q),
		.yi     (j_q),
		.acc    (acc)
	);

	// decisions on the finished sum
	assign n0_ext     = DCW'(acc[NW-1:0]);
	assign n0_lt_min  = n0_ext < DCW'(min_q);
	assign n0_gt_max  = n0_ext > DCW'(max_q);
	assign acc_zero   = (acc == '0);
	assign dot_neg    = acc[AW-1];
	assign acc_abs    = dot_neg ? -acc : acc;
	assign l_sh       = {1'b0, l_q, {LSHIFT{1'b0}}};
	assign r_val      = acc[RW-1:0];
	assign angle_keep = cneg_q ? !(l_sh < r_val) : !(l_sh > r_val);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_N0;
			k_q     <= 2'd0;
			i_q     <= '0;
			j_q     <= '0;
			seen_q  <= SEEN_NONE;
			keep_q  <= 1'b0;
			eoc_q   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				anchor_q[k]  <= '0;
				pending_q[k] <= '0;
				new_q[k]     <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: if (in_pt.valid) begin
					new_q[0] <= in_pt.point_x;
					new_q[1] <= in_pt.point_y;
					new_q[2] <= in_pt.point_z;
					eoc_q    <= in_pt.end_of_curve;
					if (seen_q == SEEN_TWO) begin
						state_q <= S_DIFF;
					end else begin
						keep_q  <= 1'b0;
						state_q <= S_EMIT_A;
					end
				end
				S_DIFF: begin
					op_q    <= OP_N0;
					k_q     <= 2'd0;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (j_q == ny_m1) begin
						j_q <= '0;
						if (i_q == nx_m1) begin
							i_q <= '0;
							if (!three_terms || k_q == 2'd2) begin
								k_q     <= 2'd0;
								state_q <= S_WAIT;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_WAIT: state_q <= S_STORE;
				S_STORE: begin
					state_q <= S_MUL;
					unique case (op_q)
						OP_N0: begin
							if (n0_lt_min) begin
								keep_q  <= 1'b0;
								state_q <= S_EMIT_A;
							end else if (n0_gt_max || acc_zero) begin
								keep_q  <= 1'b1;
								state_q <= S_EMIT_A;
							end else begin
								op_q <= OP_N1;
							end
						end
						OP_N1: begin
							if (acc_zero) begin
								keep_q  <= 1'b1;
								state_q <= S_EMIT_A;
							end else begin
								op_q <= OP_DOT;
							end
						end
						OP_DOT: begin
							if (!cneg_q && (dot_neg || acc_zero)) begin
								keep_q  <= 1'b1;
								state_q <= S_EMIT_A;
							end else if (cneg_q && !dot_neg) begin
								keep_q  <= 1'b0;
								state_q <= S_EMIT_A;
							end else begin
								op_q <= OP_DM2;
							end
						end
						OP_DM2: op_q <= OP_NN;
						OP_NN:  op_q <= OP_C2;
						OP_C2:  op_q <= OP_R;
						OP_R: begin
							keep_q  <= angle_keep;
							state_q <= S_EMIT_A;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_EMIT_A: begin
					if (!keep_q) begin
						state_q <= S_EMIT_B;
					end else if (!fifo_full) begin
						anchor_q <= pending_q;
						state_q  <= S_EMIT_B;
					end
				end
				S_EMIT_B: begin
					if (!need_b || !fifo_full) begin
						if (seen_q == SEEN_NONE) begin
							anchor_q <= new_q;
							seen_q   <= eoc_q ? SEEN_NONE : SEEN_ONE;
						end else begin
							pending_q <= new_q;
							seen_q    <= eoc_q ? SEEN_NONE : SEEN_TWO;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_DIFF) begin
			for (int k = 0; k < 3; k++) begin
				m0_q[k] <= m0_c[k];
				m1_q[k] <= m1_c[k];
				s0_q[k] <= d0[k][DW-1];
				s1_q[k] <= d1[k][DW-1];
			end
			cm_q   <= cm_c;
			cneg_q <= cos_q[COS_BITS-1];
		end
		if (state_q == S_STORE) begin
			case (op_q)
				OP_N0:   n0_q <= acc[NW-1:0];
				OP_N1:   n1_q <= acc[NW-1:0];
				OP_DOT:  dm_q <= acc_abs[NW-1:0];
				OP_DM2:  l_q  <= acc[PW-1:0];
				OP_NN:   t_q  <= acc[PW-1:0];
				OP_C2:   c2_q <= acc[C2W-1:0];
				default: ;
			endcase
		end
	end

	// result words
	assign need_b    = (seen_q == SEEN_NONE) || eoc_q;
	assign push_a    = (state_q == S_EMIT_A) && keep_q && !fifo_full;
	assign push_b    = (state_q == S_EMIT_B) && need_b && !fifo_full;
	assign fifo_push = push_a || push_b;
	assign push_data = push_a ?
		{pending_q[0], pending_q[1], pending_q[2], 1'b0} :
		{new_q[0], new_q[1], new_q[2], eoc_q};

	assign in_pt.ready = (state_q == S_IDLE);

	pdas_fifo #(
		.COORD_BITS (COORD_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (push_data),
		.full      (fifo_full),
		.out       (out_pt)
	);

	`ASSERT_NEXT(a_busy_after_accept, in_pt.valid && in_pt.ready, !in_pt.ready)
	`ASSERT_IMPL(a_no_push_when_full, fifo_push, !fifo_full)
	`ASSERT_IMPL(a_math_needs_two_points, state_q == S_DIFF, seen_q == SEEN_TWO)

endmodule

### design/pdas_mac.sv
// Shared limb multiply-accumulate unit: 32x32 product, registered, shifted into a wide sum.
module pdas_mac #(
	parameter int OPW = 96,
	parameter int LIW = 2,
	parameter int AW  = 129
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdas_pkg::mac_ctl_t    ctl,
	input  logic [OPW-1:0]        x,
	input  logic [OPW-1:0]        y,
	input  logic [LIW-1:0]        xi,
	input  logic [LIW-1:0]        yi,
	output logic signed [AW-1:0]  acc
);
	import pdas_pkg::*;

	logic [LIMB_BITS-1:0]   xl;
	logic [LIMB_BITS-1:0]   yl;
	logic [2*LIMB_BITS-1:0] prod_s1;
	logic                   neg_s1;
	logic                   issue_s1;
	logic [LIW:0]           sh_s1;
	logic [AW-1:0]          pp;
	logic signed [AW-1:0]   addend;
	logic signed [AW-1:0]   acc_q;

	assign xl = x[xi*LIMB_BITS +: LIMB_BITS];
	assign yl = y[yi*LIMB_BITS +: LIMB_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (2*LIMB_BITS)'(xl) * (2*LIMB_BITS)'(yl);
		neg_s1  <= ctl.neg;
		sh_s1   <= {1'b0, xi} + {1'b0, yi};
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (issue_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign pp     = AW'(prod_s1) << (sh_s1 * LIMB_BITS);
	assign addend = neg_s1 ? -$signed(pp) : $signed(pp);
	assign acc    = acc_q;

endmodule

### design/pdas_fifo.sv
// Two-entry output queue for kept points.
module pdas_fifo #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [3*COORD_BITS:0] push_data,
	output logic                  full,
	pdas_out_if.source            out
);
	localparam int WW = 3*COORD_BITS + 1;

	logic [WW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop = out.valid && out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign {out.kept_x, out.kept_y, out.kept_z, out.final_point} = mem_q[rd_q];
	assign out.valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);

endmodule
